### hw/rtl/pipt_pkg.sv
`timescale 1ns / 1ps

package pipt_pkg;

  // Operation codes carried in the input tuser field.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_TEST  = 1'b1;

  // Cycles between the closing-edge command and a settled crossing count.
  localparam int unsigned DRAIN_CYCLES = 3;

  // Command word from the controller to the datapath.
  typedef struct packed {
    logic start;        // clear the crossing count for a new test
    logic rd_en;        // read one vertex from the store
    logic rd_first;     // the read vertex is vertex zero
    logic rd_step;      // the read vertex closes an edge with the previous one
    logic close;        // evaluate the closing edge back to vertex zero
    logic load_result;  // copy the count into the result register
  } pipt_cmd_t;

endpackage

### hw/rtl/point_in_polygon_test_core.sv
`timescale 1ns / 1ps
// Point test: the controller walks the n vertices in use, evaluates the closing edge and
// drains the pipeline before loading the result; with fewer than two vertices it skips the walk.
// The walk reads one vertex per cycle from the single read port of the vertex store.
// Vertex write: no result. A finished result waits in an output register.
// Reset (synchronous, active low) clears control state and vertex_count; the vertex
// store is not cleared and holds undefined data until written.

module point_in_polygon_test_core import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,     // vertex_count
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,      // vertex_index[5:0], coord_x[21:6], coord_y[37:22]
  input  logic        in_tuser,      // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,     // crossing_count[6:0]
  output logic        out_tuser      // is_outside
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic                         in_fire;
  logic signed [15:0]           in_coord_x, in_coord_y;
  logic signed [COORD_BITS-1:0] coord_x_c, coord_y_c;
  pipt_cmd_t                    cmd;
  logic [AW-1:0]                rd_addr;
  logic [CW-1:0]                result_count;

  assign in_fire    = in_tvalid && in_tready;
  assign in_coord_x = in_tdata[21:6];
  assign in_coord_y = in_tdata[37:22];
  assign coord_x_c  = COORD_BITS'(in_coord_x);
  assign coord_y_c  = COORD_BITS'(in_coord_y);

  pipt_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_fire   (in_fire),
    .in_func   (in_tuser),
    .in_tready (in_tready),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  pipt_datapath #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_func     (in_tuser),
    .in_index    (in_tdata[5:0]),
    .in_x        (coord_x_c),
    .in_y        (coord_y_c),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .result_count(result_count)
  );

  // An even crossing count means the point lies outside.
  assign out_tdata = {1'b0, 7'(result_count)};
  assign out_tuser = ~result_count[0];

endmodule

### hw/rtl/pipt_ctrl.sv
`timescale 1ns / 1ps

module pipt_ctrl import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [6:0]                      cfg_wdata,
  input  logic                            in_fire,
  input  logic                            in_func,
  output logic                            in_tready,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output pipt_cmd_t                       cmd,
  output logic [$clog2(MAX_VERTICES)-1:0] rd_addr
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int DCW = $clog2(DRAIN_CYCLES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CLOSE,
    S_DRAIN,
    S_RESULT
  } state_t;

  state_t          state_r, state_nxt;
  logic [6:0]      vcount_r, vcount_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   n_sat;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [DCW-1:0]  drain_r, drain_nxt;
  pipt_cmd_t       cmd_r, cmd_nxt;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Vertex count in use, saturated to the store depth.
  assign n_sat = (32'(vcount_r) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_r);

  // Next-state and command logic.
  always_comb begin
    state_nxt     = state_r;
    vcount_nxt    = vcount_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    drain_nxt     = drain_r;
    cmd_nxt       = '0;
    rd_addr_nxt   = rd_addr_r;
    out_valid_nxt = out_valid_r;

    if (cfg_we) begin
      vcount_nxt = cfg_wdata;
    end

    // The result register fills in the cycle after the registered load command.
    if (cmd_r.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_func == FUNC_TEST)) begin
          cmd_nxt.start = 1'b1;
          n_nxt         = n_sat;
          idx_nxt       = '0;
          drain_nxt     = '0;
          // With fewer than two vertices no edge can straddle the point.
          if (n_sat < CW'(2)) begin
            state_nxt = S_DRAIN;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_nxt.rd_en    = 1'b1;
        cmd_nxt.rd_first = (idx_r == '0);
        cmd_nxt.rd_step  = (idx_r != '0);
        rd_addr_nxt      = idx_r;
        if (idx_r == AW'(n_r - CW'(1))) begin
          state_nxt = S_CLOSE;
        end else begin
          idx_nxt = idx_r + AW'(1);
        end
      end
      S_CLOSE: begin
        cmd_nxt.close = 1'b1;
        drain_nxt     = '0;
        state_nxt     = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_r == DCW'(DRAIN_CYCLES - 1)) begin
          state_nxt = S_RESULT;
        end else begin
          drain_nxt = drain_r + DCW'(1);
        end
      end
      S_RESULT: begin
        if (!out_valid_r || out_tready) begin
          cmd_nxt.load_result = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      drain_r     <= '0;
      cmd_r       <= '0;
      rd_addr_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      drain_r     <= drain_nxt;
      cmd_r       <= cmd_nxt;
      rd_addr_r   <= rd_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign cmd        = cmd_r;
  assign rd_addr    = rd_addr_r;

  // A vertex read never overlaps with accepting a new transaction.
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.rd_en |-> !in_tready)
    else $error("vertex read issued while the input is open");

  // The result register is never overwritten while it still holds a result.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.load_result |-> !out_valid_r)
    else $error("result loaded over a pending result");

  // Only one kind of command is issued in a cycle.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd_r.start, cmd_r.rd_en, cmd_r.close, cmd_r.load_result}))
    else $error("conflicting commands");

  // The walk always starts at vertex zero.
  a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.rd_first |-> (rd_addr_r == '0))
    else $error("first vertex read from a nonzero slot");

  // The closing edge is followed by the pipeline drain.
  a_close_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r.close |=> (state_r == S_DRAIN))
    else $error("closing edge not followed by drain");

endmodule

### hw/rtl/pipt_datapath.sv
`timescale 1ns / 1ps

module pipt_datapath import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_fire,
  input  logic                            in_func,
  input  logic [5:0]                      in_index,
  input  logic signed [COORD_BITS-1:0]    in_x,
  input  logic signed [COORD_BITS-1:0]    in_y,
  input  pipt_cmd_t                       cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0] rd_addr,
  output logic [$clog2(MAX_VERTICES+1)-1:0] result_count
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // Vertex store, y in the upper half and x in the lower half.
  logic [2*C-1:0] mem [MAX_VERTICES];
  logic [2*C-1:0] rd_q;

  logic signed [C-1:0] px_r, py_r;
  logic signed [C-1:0] prev_x_r, prev_y_r, v0_x_r, v0_y_r;
  logic                s1_first_r, s1_step_r, s1_close_r;

  logic signed [C-1:0] cur_x, cur_y, ax, ay, bx, by;
  logic signed [DW-1:0] dpx, dcx, ds1, ds2, ua, ud;
  logic                 straddle;

  logic signed [DW-1:0] ua_r, ud_r, s1_r, s2_r;
  logic                 s2_valid_r;
  logic signed [PW-1:0] p_r, q_r;
  logic                 s3_valid_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        result_r;

  logic wr_en;

  assign wr_en = in_fire && (in_func == FUNC_WRITE) && (32'(in_index) < 32'(MAX_VERTICES));

  // Store write on a vertex transaction, registered read for the walk.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_index)] <= {in_y, in_x};
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Test point is captured at acceptance.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r <= in_x;
      py_r <= in_y;
    end
  end

  // Stage one flags are registered from the read command, so they line up with the read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_first_r <= 1'b0;
      s1_step_r  <= 1'b0;
      s1_close_r <= 1'b0;
    end else begin
      s1_first_r <= cmd.rd_en && cmd.rd_first;
      s1_step_r  <= cmd.rd_en && cmd.rd_step;
      s1_close_r <= cmd.close;
    end
  end

  assign cur_x = rd_q[C-1:0];
  assign cur_y = rd_q[2*C-1:C];

  // Edge from the previous vertex to the current one, or back to vertex zero.
  assign ax = prev_x_r;
  assign ay = prev_y_r;
  assign bx = s1_close_r ? v0_x_r : cur_x;
  assign by = s1_close_r ? v0_y_r : cur_y;

  always_ff @(posedge clk) begin
    if (s1_first_r || s1_step_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
    end
    if (s1_first_r) begin
      v0_x_r <= cur_x;
      v0_y_r <= cur_y;
    end
  end

  // Straddle test and the differences for the cross-multiplication.
  always_comb begin
    straddle = ((ax < px_r) && (px_r < bx)) || ((ax > px_r) && (px_r > bx));
    dpx = $signed({px_r[C-1], px_r}) - $signed({bx[C-1], bx});
    dcx = $signed({ax[C-1], ax}) - $signed({bx[C-1], bx});
    ds1 = $signed({ay[C-1], ay}) - $signed({by[C-1], by});
    ds2 = $signed({py_r[C-1], py_r}) - $signed({by[C-1], by});
    ua  = dpx[DW-1] ? -dpx : dpx;
    ud  = dcx[DW-1] ? -dcx : dcx;
  end

  always_ff @(posedge clk) begin
    ua_r <= ua;
    ud_r <= ud;
    s1_r <= ds1;
    s2_r <= ds2;
  end

  // Products of both sides of the height comparison.
  always_ff @(posedge clk) begin
    p_r <= PW'(ua_r) * PW'(s1_r);
    q_r <= PW'(s2_r) * PW'(ud_r);
  end

  // Valid pipeline and crossing counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      count_r    <= '0;
    end else begin
      s2_valid_r <= (s1_step_r || s1_close_r) && straddle;
      s3_valid_r <= s2_valid_r;
      if (cmd.start) begin
        count_r <= '0;
      end else if (s3_valid_r && (p_r >= q_r)) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // Result register seen on the output channel.
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      result_r <= count_r;
    end
  end

  assign result_count = result_r;

endmodule
